@@ rtl/cfa_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the allocator.
`default_nettype none
package cfa_pkg;

   localparam int SLOTS    = 128;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int IDX_W    = $clog2(SLOTS + 1);
   localparam int OWNER_W  = 8;
   localparam int SIZE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int START_W  = 7;
   localparam int POLICY_W = 2;

   localparam logic [POLICY_W-1:0] POL_FIRST = POLICY_W'(0);
   localparam logic [POLICY_W-1:0] POL_NEXT  = POLICY_W'(1);
   localparam logic [POLICY_W-1:0] POL_BEST  = POLICY_W'(2);

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANT   = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DECIDE,
      FSM_ARM,
      FSM_WRITE,
      FSM_DONE
   } fsm_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic restart;
      logic begin_write;
      logic wr_step;
      logic fail;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic invalid;
      logic hit;
      logic at_end;
      logic at_top;
      logic best_mode;
      logic next_mode;
      logic pass_done;
      logic best_found;
      logic wr_last;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/cfa_dpath.sv @@
// Datapath of the allocator: slot map, owner memory, scan counters and result registers.
`default_nettype none
module cfa_dpath
   import cfa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [POLICY_W-1:0] csr_wr_data,
   input  wire logic [OWNER_W-1:0]  req_owner_id,
   input  wire logic [SIZE_W-1:0]   req_request_size,
   input  wire cmd_type             cmd,
   output stat_type                 stat,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [START_W-1:0]       rsp_start_slot
);

   logic [POLICY_W-1:0] policy_ff;
   logic [SLOT_W-1:0]   ptr_ff;
   logic [SLOTS-1:0]    free_ff;
   logic [OWNER_W-1:0]  owner_mem [SLOTS];

   logic [OWNER_W-1:0]  owner_ff;
   logic [IDX_W-1:0]    need_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    run_ff;
   logic [SLOT_W-1:0]   start_ff;
   logic [IDX_W-1:0]    best_len_ff;
   logic                best_found_ff;
   logic                pass_ff;
   status_type          code_ff;
   status_type          rsp_status_ff;
   logic [START_W-1:0]  rsp_start_ff;

   logic [SLOT_W-1:0]   slot_idx;
   logic                at_end;
   logic                at_top;
   logic                cur_free;
   logic [IDX_W-1:0]    run_inc;
   logic                hit;
   logic                best_take;
   logic                next_mode;
   logic                best_mode;
   logic                invalid;

   assign slot_idx  = idx_ff[SLOT_W-1:0];
   assign at_end    = (idx_ff == IDX_W'(SLOTS));
   assign at_top    = (idx_ff == IDX_W'(SLOTS - 1));
   assign cur_free  = !at_end && free_ff[slot_idx];
   assign run_inc   = run_ff + IDX_W'(1);
   assign hit       = cur_free && (run_inc >= need_ff);
   assign best_take = !cur_free && (run_ff >= need_ff)
                      && (!best_found_ff || (run_ff < best_len_ff));
   assign next_mode = (policy_ff == POL_NEXT);
   assign best_mode = (policy_ff != POL_FIRST) && (policy_ff != POL_NEXT);
   assign invalid   = (req_request_size == SIZE_W'(0))
                      || (32'(req_request_size) > 32'(SLOTS));

   always_comb begin
      stat.invalid    = invalid;
      stat.hit        = hit;
      stat.at_end     = at_end;
      stat.at_top     = at_top;
      stat.best_mode  = best_mode;
      stat.next_mode  = next_mode;
      stat.pass_done  = pass_ff;
      stat.best_found = best_found_ff;
      stat.wr_last    = (run_ff == IDX_W'(1));
   end

   // Map state that reset defines.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_BEST;
         ptr_ff    <= '0;
         free_ff   <= '1;
      end else begin
         if (csr_wr_en) begin
            policy_ff <= csr_wr_data;
         end
         if (cmd.wr_step) begin
            free_ff[slot_idx] <= 1'b0;
            if (stat.wr_last) begin
               ptr_ff <= at_top ? '0 : SLOT_W'(slot_idx + SLOT_W'(1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_step) begin
         owner_mem[slot_idx] <= owner_ff;
      end
   end

   // Request registers, scan and write counters, best-fit candidate and result code.
   always_ff @(posedge clock) begin
      priority if (cmd.load) begin
         owner_ff      <= req_owner_id;
         need_ff       <= IDX_W'(req_request_size);
         idx_ff        <= next_mode ? IDX_W'(ptr_ff) : '0;
         run_ff        <= '0;
         best_found_ff <= 1'b0;
         pass_ff       <= 1'b0;
         code_ff       <= invalid ? ST_INVALID : ST_GRANT;
      end else if (cmd.restart) begin
         idx_ff  <= '0;
         run_ff  <= '0;
         pass_ff <= 1'b1;
      end else if (cmd.fail) begin
         code_ff <= ST_NOFIT;
      end else if (cmd.step) begin
         run_ff <= cur_free ? run_inc : '0;
         idx_ff <= idx_ff + IDX_W'(1);
         if (best_mode) begin
            if (best_take) begin
               best_len_ff   <= run_ff;
               start_ff      <= SLOT_W'(idx_ff - run_ff);
               best_found_ff <= 1'b1;
            end
         end else if (hit) begin
            start_ff <= SLOT_W'(idx_ff + IDX_W'(1) - need_ff);
         end
      end else if (cmd.begin_write) begin
         idx_ff <= IDX_W'(start_ff);
         run_ff <= need_ff;
      end else if (cmd.wr_step) begin
         idx_ff <= idx_ff + IDX_W'(1);
         run_ff <= run_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_status_ff <= code_ff;
         rsp_start_ff  <= (code_ff == ST_GRANT) ? START_W'(start_ff) : '0;
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_start_slot = rsp_start_ff;

endmodule
`default_nettype wire

@@ rtl/cfa_ctrl.sv @@
// Controller state machine of the allocator: sequences scan, write and result transfer.
`default_nettype none
module cfa_ctrl
   import cfa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   fsm_state_type state_ff;
   fsm_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = stat.invalid ? FSM_DONE : FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if (stat.best_mode) begin
               if (stat.at_end) begin
                  state_in = FSM_DECIDE;
               end
            end else if (stat.hit) begin
               state_in = FSM_ARM;
            end else if (stat.at_top && !(stat.next_mode && !stat.pass_done)) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DECIDE: begin
            state_in = stat.best_found ? FSM_ARM : FSM_DONE;
         end
         FSM_ARM: begin
            state_in = FSM_WRITE;
         end
         FSM_WRITE: begin
            if (stat.wr_last) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         FSM_SCAN: begin
            cmd.step = 1'b1;
            if (!stat.best_mode && !stat.hit && stat.at_top) begin
               if (stat.next_mode && !stat.pass_done) begin
                  cmd.restart = 1'b1;
               end else begin
                  cmd.fail = 1'b1;
               end
            end
         end
         FSM_DECIDE: begin
            cmd.fail = !stat.best_found;
         end
         FSM_ARM: begin
            cmd.begin_write = 1'b1;
         end
         FSM_WRITE: begin
            cmd.wr_step = 1'b1;
         end
         FSM_DONE: begin
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ rtl/contiguous_fit_allocator_unit.sv @@
// Top level of the contiguous slot allocator: controller and datapath.
//
// The unit hands out runs of contiguous slots from a 128-slot map under a
// first fit, next fit or best fit policy chosen by the policy register
// (reset value best fit; code 3 also means best fit). It accepts one request
// at a time, and a new request can be taken while the previous result is still
// waiting in the output register. One slot is examined per clock; a best fit
// scan covers the whole map, and a next fit search may wrap around once to
// slot 0. The granted slots are then marked in the map. A zero or oversized
// size is answered without a scan. Slots are freed only by reset. The user
// must write the policy register only while no request is in flight; the
// block itself does not enforce this.
`default_nettype none
module contiguous_fit_allocator_unit
   import cfa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [POLICY_W-1:0] csr_wr_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [OWNER_W-1:0]  req_owner_id,
   input  wire logic [SIZE_W-1:0]   req_request_size,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [START_W-1:0]       rsp_start_slot
);

   cmd_type  cmd;
   stat_type stat;

   cfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cfa_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_owner_id     (req_owner_id),
      .req_request_size (req_request_size),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_start_slot   (rsp_start_slot)
   );

endmodule
`default_nettype wire
